FILE: rtl/tgcc_pkg.sv
// Shared types, constants and helpers for the triangle grid cell cover block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package tgcc_pkg;

	localparam int unsigned MAX_SPAN   = 4;
	localparam int unsigned DIM_MAX    = 1024;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned PROD_SHIFT = 2 * FRAC_BITS;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CELL_W  = 10;
	localparam int unsigned DIM_W   = 11;
	localparam int unsigned INDEX_W = 30;
	localparam int unsigned PLANE_W = 21;
	localparam int unsigned SPAN_W  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

	localparam int unsigned CALC_CYCLES = 7;
	localparam int unsigned CALC_CNT_W  = $clog2(CALC_CYCLES);

	typedef enum logic [2:0] {
		CFG_ORIGIN_X     = 3'd0,
		CFG_ORIGIN_Y     = 3'd1,
		CFG_ORIGIN_Z     = 3'd2,
		CFG_INV_CELL     = 3'd3,
		CFG_CELLS_X      = 3'd4,
		CFG_CELLS_Y      = 3'd5,
		CFG_CELLS_Z      = 3'd6,
		CFG_UNUSED       = 3'd7
	} tgcc_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WALK
	} tgcc_state_t;

	typedef struct packed {
		logic [CELL_W-1:0] lo;
		logic [CELL_W-1:0] hi;
	} tgcc_range_t;

	typedef struct packed {
		logic [CELL_W-1:0]  lo_x;
		logic [CELL_W-1:0]  lo_y;
		logic [CELL_W-1:0]  lo_z;
		logic [SPAN_W-1:0]  n_x;
		logic [SPAN_W-1:0]  n_y;
		logic [SPAN_W-1:0]  n_z;
		logic [DIM_W-1:0]   dx;
		logic [PLANE_W-1:0] dxdy;
		logic [INDEX_W-1:0] base;
		logic               clipped;
	} tgcc_box_t;

	// Cell counts of zero read as one, counts above the maximum read as the maximum.
	function automatic logic [DIM_W-1:0] tgcc_eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(DIM_MAX)) begin
			r = DIM_W'(DIM_MAX);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tgcc_axis_lane.sv
// One axis lane: bounding range of three vertex coordinates mapped to clamped cell numbers.
// Four register stages: min/max, origin offset, reciprocal multiply, truncate and clamp.
// Depends on tgcc_pkg.
`default_nettype none

module tgcc_axis_lane
	import tgcc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [COORD_W-1:0] coord_a,
	input  wire logic signed [COORD_W-1:0] coord_b,
	input  wire logic signed [COORD_W-1:0] coord_c,
	input  wire logic signed [COORD_W-1:0] origin,
	input  wire logic        [COORD_W-1:0] inv_cell,
	input  wire logic        [DIM_W-1:0]   cells,
	output tgcc_range_t                    range
);

	logic signed [COORD_W-1:0] mn_s1, mx_s1;
	logic signed [COORD_W:0]   dmn_s2, dmx_s2;
	logic        [63:0]        pmn_s3, pmx_s3;
	logic                      pos_mn_s3, pos_mx_s3;
	tgcc_range_t               range_s4;

	logic signed [COORD_W-1:0] min_ab, max_ab;
	logic        [63:0]        qmn, qmx;
	logic        [DIM_W-1:0]   dim_eff;
	logic        [CELL_W-1:0]  dim_m1;

	assign min_ab  = (coord_a < coord_b) ? coord_a : coord_b;
	assign max_ab  = (coord_a > coord_b) ? coord_a : coord_b;
	assign dim_eff = tgcc_eff_dim(cells);
	assign dim_m1  = CELL_W'(dim_eff - DIM_W'(1));
	assign qmn     = pos_mn_s3 ? (pmn_s3 >> PROD_SHIFT) : 64'd0;
	assign qmx     = pos_mx_s3 ? (pmx_s3 >> PROD_SHIFT) : 64'd0;

	always_ff @(posedge clk) begin
		mn_s1     <= (min_ab < coord_c) ? min_ab : coord_c;
		mx_s1     <= (max_ab > coord_c) ? max_ab : coord_c;
		dmn_s2    <= (COORD_W+1)'(mn_s1) - (COORD_W+1)'(origin);
		dmx_s2    <= (COORD_W+1)'(mx_s1) - (COORD_W+1)'(origin);
		pos_mn_s3 <= !dmn_s2[COORD_W] && (dmn_s2[COORD_W-1:0] != '0);
		pos_mx_s3 <= !dmx_s2[COORD_W] && (dmx_s2[COORD_W-1:0] != '0);
		pmn_s3    <= 64'(dmn_s2[COORD_W-1:0]) * 64'(inv_cell);
		pmx_s3    <= 64'(dmx_s2[COORD_W-1:0]) * 64'(inv_cell);
		range_s4.lo <= (qmn > 64'(dim_m1)) ? dim_m1 : qmn[CELL_W-1:0];
		range_s4.hi <= (qmx > 64'(dim_m1)) ? dim_m1 : qmx[CELL_W-1:0];
	end

	assign range = range_s4;

endmodule

`default_nettype wire

FILE: rtl/tgcc_merge.sv
// Merges the three lane ranges: clips wide spans, then forms the base flat index and strides.
// Two register stages; the first holds two narrow multipliers, the second one.
// Depends on tgcc_pkg.
`default_nettype none

module tgcc_merge
	import tgcc_pkg::*;
(
	input  wire logic             clk,
	input  wire tgcc_range_t      range_x,
	input  wire tgcc_range_t      range_y,
	input  wire tgcc_range_t      range_z,
	input  wire logic [DIM_W-1:0] cells_x,
	input  wire logic [DIM_W-1:0] cells_y,
	output tgcc_box_t             box
);

	localparam logic [CELL_W-1:0] SPAN_LIM = CELL_W'(MAX_SPAN - 1);

	logic [CELL_W-1:0]  lo_x_s1, lo_y_s1, lo_z_s1;
	logic [SPAN_W-1:0]  n_x_s1, n_y_s1, n_z_s1;
	logic [DIM_W-1:0]   dx_s1;
	logic [PLANE_W-1:0] dxdy_s1;
	logic [PLANE_W:0]   t_s1;
	logic               clip_s1;
	tgcc_box_t          box_s2;

	logic [CELL_W-1:0]  sp_x, sp_y, sp_z;
	logic [DIM_W-1:0]   dx_eff, dy_eff;

	assign sp_x   = range_x.hi - range_x.lo;
	assign sp_y   = range_y.hi - range_y.lo;
	assign sp_z   = range_z.hi - range_z.lo;
	assign dx_eff = tgcc_eff_dim(cells_x);
	assign dy_eff = tgcc_eff_dim(cells_y);

	always_ff @(posedge clk) begin
		lo_x_s1 <= range_x.lo;
		lo_y_s1 <= range_y.lo;
		lo_z_s1 <= range_z.lo;
		n_x_s1  <= (sp_x > SPAN_LIM) ? SPAN_LIM[SPAN_W-1:0] : sp_x[SPAN_W-1:0];
		n_y_s1  <= (sp_y > SPAN_LIM) ? SPAN_LIM[SPAN_W-1:0] : sp_y[SPAN_W-1:0];
		n_z_s1  <= (sp_z > SPAN_LIM) ? SPAN_LIM[SPAN_W-1:0] : sp_z[SPAN_W-1:0];
		clip_s1 <= (sp_x > SPAN_LIM) || (sp_y > SPAN_LIM) || (sp_z > SPAN_LIM);
		dx_s1   <= dx_eff;
		dxdy_s1 <= PLANE_W'(dx_eff) * PLANE_W'(dy_eff);
		t_s1    <= (PLANE_W+1)'(range_y.lo)
			+ (PLANE_W+1)'(dy_eff) * (PLANE_W+1)'(range_z.lo);

		box_s2.lo_x    <= lo_x_s1;
		box_s2.lo_y    <= lo_y_s1;
		box_s2.lo_z    <= lo_z_s1;
		box_s2.n_x     <= n_x_s1;
		box_s2.n_y     <= n_y_s1;
		box_s2.n_z     <= n_z_s1;
		box_s2.dx      <= dx_s1;
		box_s2.dxdy    <= dxdy_s1;
		box_s2.clipped <= clip_s1;
		box_s2.base    <= INDEX_W'(lo_x_s1) + INDEX_W'(dx_s1) * INDEX_W'(t_s1);
	end

	assign box = box_s2;

endmodule

`default_nettype wire

FILE: rtl/tgcc_cell_walk.sv
// Cell walker: steps through the clipped box in x-outer, z-inner order, one cell per beat.
// Flat indices advance by adding strides; the result register sits on the output channel.
// Depends on tgcc_pkg.
`default_nettype none

module tgcc_cell_walk
	import tgcc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire tgcc_box_t           box,
	output logic                     last_sent,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [CELL_W-1:0]        cell_x,
	output logic [CELL_W-1:0]        cell_y,
	output logic [CELL_W-1:0]        cell_z,
	output logic [INDEX_W-1:0]       flat_index,
	output logic                     last_cell,
	output logic                     span_clipped
);

	logic               active_q, out_valid_q;
	tgcc_box_t          box_q;
	logic [CELL_W-1:0]  cx_q, cy_q, cz_q;
	logic [SPAN_W-1:0]  kx_q, ky_q, kz_q;
	logic [INDEX_W-1:0] idx_q, idx_x_q, idx_y_q;
	logic [CELL_W-1:0]  cell_x_q, cell_y_q, cell_z_q;
	logic [INDEX_W-1:0] flat_index_q;
	logic               last_cell_q, clipped_q;

	logic emit, last_now;

	assign emit      = active_q && (!out_valid_q || !out_stall);
	assign last_now  = (kx_q == box_q.n_x) && (ky_q == box_q.n_y) && (kz_q == box_q.n_z);
	assign last_sent = emit && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
			end else if (last_sent) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			box_q   <= box;
			cx_q    <= box.lo_x;
			cy_q    <= box.lo_y;
			cz_q    <= box.lo_z;
			kx_q    <= '0;
			ky_q    <= '0;
			kz_q    <= '0;
			idx_q   <= box.base;
			idx_x_q <= box.base;
			idx_y_q <= box.base;
		end else if (emit) begin
			cell_x_q     <= cx_q;
			cell_y_q     <= cy_q;
			cell_z_q     <= cz_q;
			flat_index_q <= idx_q;
			last_cell_q  <= last_now;
			clipped_q    <= box_q.clipped;
			if (kz_q != box_q.n_z) begin
				kz_q  <= kz_q + SPAN_W'(1);
				cz_q  <= cz_q + CELL_W'(1);
				idx_q <= idx_q + INDEX_W'(box_q.dxdy);
			end else if (ky_q != box_q.n_y) begin
				kz_q    <= '0;
				cz_q    <= box_q.lo_z;
				ky_q    <= ky_q + SPAN_W'(1);
				cy_q    <= cy_q + CELL_W'(1);
				idx_y_q <= idx_y_q + INDEX_W'(box_q.dx);
				idx_q   <= idx_y_q + INDEX_W'(box_q.dx);
			end else begin
				kz_q    <= '0;
				ky_q    <= '0;
				cz_q    <= box_q.lo_z;
				cy_q    <= box_q.lo_y;
				kx_q    <= kx_q + SPAN_W'(1);
				cx_q    <= cx_q + CELL_W'(1);
				idx_x_q <= idx_x_q + INDEX_W'(1);
				idx_y_q <= idx_x_q + INDEX_W'(1);
				idx_q   <= idx_x_q + INDEX_W'(1);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_x       = cell_x_q;
	assign cell_y       = cell_y_q;
	assign cell_z       = cell_z_q;
	assign flat_index   = flat_index_q;
	assign last_cell    = last_cell_q;
	assign span_clipped = clipped_q;

endmodule

`default_nettype wire

FILE: rtl/triangle_grid_cell_cover_top.sv
// Triangle grid cell cover, top level: configuration registers, input capture, sequencer,
// three axis lanes, the merge stage and the cell walker.
// Depends on tgcc_pkg, tgcc_axis_lane, tgcc_merge and tgcc_cell_walk.
//
// Usage: one input beat carries a triangle as three signed Q16.16 vertices. The block maps
// its bounding box onto the configured uniform grid and sends one output beat per covered
// cell, x outermost and z innermost, with the flat index x + dx*(y + dy*z). The final
// beat of a triangle has last_cell set; span_clipped is set on every beat of a triangle
// whose box was wider than four cells on some axis. Registers are written through
// cfg_we/cfg_index/cfg_data while the block is idle; unused indices are ignored.
// The first cell of a triangle passes the four lane stages, the two merge stages, the walker
// load and the output register before it is valid; then one cell follows per cycle while
// the receiver does not stall. One triangle is worked on at a time; in_stall is high from
// acceptance until the last cell has been moved into the output register. That register
// lets the next triangle be taken while the last cell still waits. When the receiver
// stalls, the output holds and the walker pauses. Reset clears the control state and
// loads the register reset values.
`default_nettype none

module triangle_grid_cell_cover_top
	import tgcc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [COORD_W-1:0]        cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [COORD_W-1:0] vertex_a_x,
	input  wire logic signed [COORD_W-1:0] vertex_a_y,
	input  wire logic signed [COORD_W-1:0] vertex_a_z,
	input  wire logic signed [COORD_W-1:0] vertex_b_x,
	input  wire logic signed [COORD_W-1:0] vertex_b_y,
	input  wire logic signed [COORD_W-1:0] vertex_b_z,
	input  wire logic signed [COORD_W-1:0] vertex_c_x,
	input  wire logic signed [COORD_W-1:0] vertex_c_y,
	input  wire logic signed [COORD_W-1:0] vertex_c_z,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [CELL_W-1:0]              cell_x,
	output logic [CELL_W-1:0]              cell_y,
	output logic [CELL_W-1:0]              cell_z,
	output logic [INDEX_W-1:0]             flat_index,
	output logic                           last_cell,
	output logic                           span_clipped
);

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic        [COORD_W-1:0] inv_cell_q;
	logic        [DIM_W-1:0]   cells_x_q, cells_y_q, cells_z_q;

	logic signed [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;

	tgcc_state_t            state_q, state_d;
	logic [CALC_CNT_W-1:0]  cnt_q;
	logic                   in_accept, start, last_sent;
	tgcc_range_t            range_x, range_y, range_z;
	tgcc_box_t              box;
	tgcc_cfg_idx_t          cfg_sel;

	assign cfg_sel   = tgcc_cfg_idx_t'(cfg_index);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			inv_cell_q <= COORD_W'(65536);
			cells_x_q  <= DIM_W'(1);
			cells_y_q  <= DIM_W'(1);
			cells_z_q  <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_sel)
				CFG_ORIGIN_X: begin
					origin_x_q <= cfg_data;
				end
				CFG_ORIGIN_Y: begin
					origin_y_q <= cfg_data;
				end
				CFG_ORIGIN_Z: begin
					origin_z_q <= cfg_data;
				end
				CFG_INV_CELL: begin
					inv_cell_q <= cfg_data;
				end
				CFG_CELLS_X: begin
					cells_x_q <= cfg_data[DIM_W-1:0];
				end
				CFG_CELLS_Y: begin
					cells_y_q <= cfg_data[DIM_W-1:0];
				end
				CFG_CELLS_Z: begin
					cells_z_q <= cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ax_q <= vertex_a_x;
			ay_q <= vertex_a_y;
			az_q <= vertex_a_z;
			bx_q <= vertex_b_x;
			by_q <= vertex_b_y;
			bz_q <= vertex_b_z;
			cx_q <= vertex_c_x;
			cy_q <= vertex_c_y;
			cz_q <= vertex_c_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CALC) begin
				cnt_q <= cnt_q + CALC_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (cnt_q == CALC_CNT_W'(CALC_CYCLES - 1)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (last_sent) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		start    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_CALC: begin
				start = (cnt_q == CALC_CNT_W'(CALC_CYCLES - 1));
			end
			ST_WALK: begin
			end
			default: begin
			end
		endcase
	end

	tgcc_axis_lane u_lane_x (
		.clk      (clk),
		.coord_a  (ax_q),
		.coord_b  (bx_q),
		.coord_c  (cx_q),
		.origin   (origin_x_q),
		.inv_cell (inv_cell_q),
		.cells    (cells_x_q),
		.range    (range_x)
	);

	tgcc_axis_lane u_lane_y (
		.clk      (clk),
		.coord_a  (ay_q),
		.coord_b  (by_q),
		.coord_c  (cy_q),
		.origin   (origin_y_q),
		.inv_cell (inv_cell_q),
		.cells    (cells_y_q),
		.range    (range_y)
	);

	tgcc_axis_lane u_lane_z (
		.clk      (clk),
		.coord_a  (az_q),
		.coord_b  (bz_q),
		.coord_c  (cz_q),
		.origin   (origin_z_q),
		.inv_cell (inv_cell_q),
		.cells    (cells_z_q),
		.range    (range_z)
	);

	tgcc_merge u_merge (
		.clk     (clk),
		.range_x (range_x),
		.range_y (range_y),
		.range_z (range_z),
		.cells_x (cells_x_q),
		.cells_y (cells_y_q),
		.box     (box)
	);

	tgcc_cell_walk u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.box          (box),
		.last_sent    (last_sent),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.cell_z       (cell_z),
		.flat_index   (flat_index),
		.last_cell    (last_cell),
		.span_clipped (span_clipped)
	);

endmodule

`default_nettype wire

FILE: test/tgcc_cover_checker.sv
// Checker for the triangle grid cell cover block: follows register writes, predicts the cells
// of every accepted triangle and compares them with the output beats in order.
// Depends on tgcc_pkg for widths, register indexes and the span limit.
`timescale 1ns / 1ps

module tgcc_cover_checker
	import tgcc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [0:8][COORD_W-1:0]   vertices,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [CELL_W-1:0]         cell_x,
	input  logic [CELL_W-1:0]         cell_y,
	input  logic [CELL_W-1:0]         cell_z,
	input  logic [INDEX_W-1:0]        flat_index,
	input  logic                      last_cell,
	input  logic                      span_clipped,
	input  logic                      run_done,
	output int                        mismatches,
	output int                        pending
);

	typedef struct {
		logic [CELL_W-1:0]  x;
		logic [CELL_W-1:0]  y;
		logic [CELL_W-1:0]  z;
		logic [INDEX_W-1:0] index;
		logic               last;
		logic               clipped;
	} cell_beat_t;

	cell_beat_t                cells_due [$];
	logic signed [COORD_W-1:0] grid_origin [3];
	logic [COORD_W-1:0]        recip;
	logic [DIM_W-1:0]          cell_count [3];
	bit                        end_checked;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 100) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	function automatic logic [63:0] usable_dim(input logic [DIM_W-1:0] n);
		if (n == '0) begin
			return 64'd1;
		end
		if (n > DIM_W'(DIM_MAX)) begin
			return 64'(DIM_MAX);
		end
		return 64'(n);
	endfunction

	function automatic logic [63:0] cell_of(input logic signed [COORD_W-1:0] coord,
			input logic signed [COORD_W-1:0] org, input logic [63:0] dim);
		longint      offset;
		logic [63:0] magnitude;
		logic [63:0] q;
		offset = longint'(coord) - longint'(org);
		if (offset <= 0) begin
			return 64'd0;
		end
		magnitude = offset;
		q = (magnitude * {32'd0, recip}) >> PROD_SHIFT;
		if (q > dim - 64'd1) begin
			q = dim - 64'd1;
		end
		return q;
	endfunction

	task automatic expand_triangle(input logic [0:8][COORD_W-1:0] v);
		logic [63:0]               dim [3];
		logic [63:0]               lo [3];
		logic [63:0]               hi [3];
		logic [63:0]               flat;
		logic signed [COORD_W-1:0] p, q, r, mn, mx;
		logic                      clipped;
		cell_beat_t                beat;
		clipped = 1'b0;
		for (int a = 0; a < 3; a++) begin
			dim[a] = usable_dim(cell_count[a]);
			p = v[a];
			q = v[3 + a];
			r = v[6 + a];
			mn = p;
			mx = p;
			if (q < mn) mn = q;
			if (r < mn) mn = r;
			if (q > mx) mx = q;
			if (r > mx) mx = r;
			lo[a] = cell_of(mn, grid_origin[a], dim[a]);
			hi[a] = cell_of(mx, grid_origin[a], dim[a]);
			if (hi[a] - lo[a] + 64'd1 > 64'(MAX_SPAN)) begin
				hi[a] = lo[a] + 64'(MAX_SPAN) - 64'd1;
				clipped = 1'b1;
			end
		end
		for (int x = int'(lo[0]); x <= int'(hi[0]); x++) begin
			for (int y = int'(lo[1]); y <= int'(hi[1]); y++) begin
				for (int z = int'(lo[2]); z <= int'(hi[2]); z++) begin
					flat = 64'(x) + dim[0] * (64'(y) + dim[1] * 64'(z));
					beat.x = CELL_W'(x);
					beat.y = CELL_W'(y);
					beat.z = CELL_W'(z);
					beat.index = flat[INDEX_W-1:0];
					beat.last = (x == int'(hi[0])) && (y == int'(hi[1])) && (z == int'(hi[2]));
					beat.clipped = clipped;
					cells_due.insert(cells_due.size(), beat);
				end
			end
		end
	endtask

	task automatic check_beat();
		cell_beat_t want;
		if (cells_due.size() == 0) begin
			report_mismatch($sformatf("cell (%0d,%0d,%0d) with no cell expected",
				cell_x, cell_y, cell_z));
			return;
		end
		want = cells_due.pop_front();
		if (cell_x !== want.x)
			report_mismatch($sformatf("cell_x %0d, expected %0d", cell_x, want.x));
		if (cell_y !== want.y)
			report_mismatch($sformatf("cell_y %0d, expected %0d", cell_y, want.y));
		if (cell_z !== want.z)
			report_mismatch($sformatf("cell_z %0d, expected %0d", cell_z, want.z));
		if (flat_index !== want.index)
			report_mismatch($sformatf("flat_index %0d, expected %0d", flat_index, want.index));
		if (last_cell !== want.last)
			report_mismatch($sformatf("last_cell %b, expected %b", last_cell, want.last));
		if (span_clipped !== want.clipped)
			report_mismatch($sformatf("span_clipped %b, expected %b", span_clipped,
				want.clipped));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				grid_origin[a] = '0;
				cell_count[a] = DIM_W'(1);
			end
			recip = 32'd65536;
			cells_due.delete();
			end_checked = 1'b0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X: grid_origin[0] = cfg_data;
					CFG_ORIGIN_Y: grid_origin[1] = cfg_data;
					CFG_ORIGIN_Z: grid_origin[2] = cfg_data;
					CFG_INV_CELL: recip = cfg_data;
					CFG_CELLS_X:  cell_count[0] = cfg_data[DIM_W-1:0];
					CFG_CELLS_Y:  cell_count[1] = cfg_data[DIM_W-1:0];
					CFG_CELLS_Z:  cell_count[2] = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				check_beat();
			end
			if (in_valid && !in_stall) begin
				expand_triangle(vertices);
			end
			if (run_done && !end_checked) begin
				end_checked = 1'b1;
				if (cells_due.size() != 0) begin
					report_mismatch($sformatf("%0d expected cells never arrived",
						cells_due.size()));
				end
			end
			pending <= cells_due.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Top of the triangle grid cell cover testbench: clock, reset, register writes, triangle
// stimulus with sender gaps and receiver stalls, and the verdict.
// Depends on tgcc_pkg, triangle_grid_cell_cover_top and tgcc_cover_checker.
`timescale 1ns / 1ps

module tb_top;
	import tgcc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SEGMENTS = 8;
	localparam int SEGMENT_ITEMS = 40;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef logic [0:8][COORD_W-1:0] triangle_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_stall;
	triangle_t          vtx;
	logic               out_valid;
	logic               out_stall;
	logic [CELL_W-1:0]  cell_x;
	logic [CELL_W-1:0]  cell_y;
	logic [CELL_W-1:0]  cell_z;
	logic [INDEX_W-1:0] flat_index;
	logic               last_cell;
	logic               span_clipped;
	logic               run_done;
	int                 mismatches;
	int                 pending;
	int                 cycles;
	int                 idle_pct;
	int                 stall_pct;

	logic signed [31:0] cur_org [3];
	logic [31:0]        cur_inv;
	logic [DIM_W-1:0]   cur_dim [3];

	int idle_by_phase [4] = '{0, 59, 0, 11};
	int stall_by_phase [4] = '{0, 0, 59, 11};

	triangle_grid_cell_cover_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_a_x   (vtx[0]),
		.vertex_a_y   (vtx[1]),
		.vertex_a_z   (vtx[2]),
		.vertex_b_x   (vtx[3]),
		.vertex_b_y   (vtx[4]),
		.vertex_b_z   (vtx[5]),
		.vertex_c_x   (vtx[6]),
		.vertex_c_y   (vtx[7]),
		.vertex_c_z   (vtx[8]),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.cell_z       (cell_z),
		.flat_index   (flat_index),
		.last_cell    (last_cell),
		.span_clipped (span_clipped)
	);

	tgcc_cover_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertices     (vtx),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.cell_z       (cell_z),
		.flat_index   (flat_index),
		.last_cell    (last_cell),
		.span_clipped (span_clipped),
		.run_done     (run_done),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input tgcc_cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_grid(input logic [31:0] ox, oy, oz, inv, nx, ny, nz);
		cur_org[0] = ox;
		cur_org[1] = oy;
		cur_org[2] = oz;
		cur_inv = inv;
		cur_dim[0] = nx[DIM_W-1:0];
		cur_dim[1] = ny[DIM_W-1:0];
		cur_dim[2] = nz[DIM_W-1:0];
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_INV_CELL, inv);
		write_reg(CFG_CELLS_X, nx);
		write_reg(CFG_CELLS_Y, ny);
		write_reg(CFG_CELLS_Z, nz);
	endtask

	// Register writes must wait until every cell has left; the block does not check.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_tri(input triangle_t t);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		vtx <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic triangle_t make_tri(input logic [31:0] ax, ay, az, bx, by, bz,
			cx, cy, cz);
		return {ax, ay, az, bx, by, bz, cx, cy, cz};
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic random_grid();
		logic [31:0] org [3];
		logic [31:0] count [3];
		logic [31:0] inv;
		logic [10:0] n;
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 3) == 0) begin
				org[a] = $urandom;
			end else begin
				org[a] = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			end
			case ($urandom_range(0, 7))
				0: n = 11'd1024;
				1: n = 11'($urandom_range(0, 2047));
				default: n = 11'($urandom_range(1, 12));
			endcase
			count[a] = {($urandom_range(0, 7) == 0) ? 21'($urandom) : 21'd0, n};
		end
		case ($urandom_range(0, 6))
			0: inv = 32'h0000_4000;
			1: inv = 32'h0004_0000;
			2: inv = 32'($urandom_range(4096, 32'h0010_0000));
			3: inv = $urandom;
			4: inv = 32'h0000_8000;
			default: inv = ONE;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, $urandom);
		end
		load_grid(org[0], org[1], org[2], inv, count[0], count[1], count[2]);
	endtask

	function automatic triangle_t random_triangle();
		triangle_t t;
		longint    cell_len;
		longint    anchor;
		int        kind;
		int        spread;
		kind = $urandom_range(0, 99);
		cell_len = (cur_inv == 0) ? 64'sh1_0000_0000 : 64'sh1_0000_0000 / longint'(cur_inv);
		if (kind < 10) begin
			for (int i = 0; i < 9; i++) t[i] = $urandom;
		end else if (kind < 20) begin
			for (int i = 0; i < 9; i++) begin
				case ($urandom_range(0, 6))
					0: t[i] = 32'h8000_0000;
					1: t[i] = 32'h7FFF_FFFF;
					2: t[i] = 32'h0000_0000;
					3: t[i] = cur_org[i % 3];
					4: t[i] = cur_org[i % 3] + 32'd1;
					5: t[i] = cur_org[i % 3] - 32'd1;
					default: t[i] = $urandom;
				endcase
			end
		end else begin
			spread = ($urandom_range(0, 9) < 6) ? 1 : (($urandom_range(0, 3) < 3) ? 3 : 6);
			for (int a = 0; a < 3; a++) begin
				anchor = longint'(cur_org[a])
					+ longint'($urandom_range(0, cur_dim[a])) * cell_len
					+ longint'($urandom) % cell_len;
				for (int k = 0; k < 3; k++) begin
					if (kind < 25) begin
						t[3 * k + a] = clamp32(anchor);
					end else begin
						t[3 * k + a] = clamp32(anchor
							+ longint'($urandom) % (spread * cell_len + 1) - cell_len / 4);
					end
				end
			end
		end
		return t;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ORIGIN_X;
		cfg_data = '0;
		in_valid = 1'b0;
		vtx = '0;
		out_stall = 1'b0;
		run_done = 1'b0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		cur_org = '{default: '0};
		cur_inv = ONE;
		cur_dim = '{default: DIM_W'(1)};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register values after reset: a single cell grid.
		send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tri({9{32'h7FFF_FFFF}});
		send_tri({9{32'h8000_0000}});
		send_tri(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));

		// Unit cells on an eight cell cube.
		quiesce();
		load_grid(0, 0, 0, ONE, 8, 8, 8);
		send_tri(make_tri(32'h18000, 32'h28000, 32'h38000, 32'h14000, 32'h2C000, 32'h31000,
			32'h1F000, 32'h21000, 32'h3F000));
		send_tri(make_tri(32'hFFFF_0000, 32'h8000, 0, 32'hFFFB_0000, 32'h4000, 32'h8000,
			32'h8000, 32'h8000, 32'hFFFF_FFFF));
		send_tri(make_tri(32'h60000, 32'h64_0000, 32'h70000, 32'h7FFF_FFFF, 32'h10000,
			32'h70000, 32'h68000, 32'h18000, 32'h7FFFF));
		send_tri(make_tri(0, 0, 0, 32'hA0000, 32'h10000, 0, 32'h50000, 32'h8000, 32'h8000));
		send_tri(make_tri(0, 0, 0, 32'h7FFFF, 32'h7FFFF, 32'h7FFFF, 32'h30000, 32'h30000,
			32'h30000));
		send_tri(make_tri(32'h20000, 32'h1FFFF, 32'h10000, 32'h20000, 32'h1FFFF, 32'h10000,
			32'h20000, 32'h1FFFF, 32'h10000));
		send_tri(make_tri(0, 1, 0, 1, 0, 1, 0, 0, 1));

		// Extreme origins and the largest reciprocal; cell counts out of range and at the limit.
		quiesce();
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		load_grid(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 32'h0000_07FF,
			32'hFFFF_F800, 32'd1024);
		send_tri(make_tri(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
		send_tri({9{32'h7FFF_FFFF}});
		send_tri({9{32'h8000_0000}});
		send_tri(make_tri(32'h8000_0001, 0, 1, 32'h8000_0002, 0, 2, 32'h8000_0003, 0, 3));

		// Zero reciprocal maps everything to the first cell.
		quiesce();
		load_grid(32'hFFFF_0000, 0, ONE, 0, 5, 5, 5);
		send_tri(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_tri(make_tri(32'h50000, 32'h20000, 32'h90000, 32'h10000, 32'h30000, 32'h40000,
			32'h20000, 32'h60000, 32'h10000));

		// Smallest nonzero reciprocal on the largest grid.
		quiesce();
		load_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1024, 1024, 1024);
		send_tri({9{32'h7FFF_FFFF}});

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			quiesce();
			idle_pct = idle_by_phase[seg % 4];
			stall_pct = stall_by_phase[seg % 4];
			random_grid();
			repeat (SEGMENT_ITEMS) send_tri(random_triangle());
		end

		quiesce();
		@(negedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/tgcc_pkg.sv
rtl/tgcc_axis_lane.sv
rtl/tgcc_merge.sv
rtl/tgcc_cell_walk.sv
rtl/triangle_grid_cell_cover_top.sv
test/tgcc_cover_checker.sv
test/tb_top.sv
